FILE: rtl/core/gbsop_pkg.sv
// ----------------------------------------------------------------------------
// gbsop_pkg
// Shared types and constants for the greedy-by-size offset planner.
// ----------------------------------------------------------------------------
package gbsop_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int MAX_RECORDS = 256;
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int REC_W   = $clog2(MAX_RECORDS);
  localparam int SCNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int RCNT_W  = $clog2(MAX_RECORDS + 1);

  localparam logic       OP_PLACE = 1'b0;
  localparam logic       OP_CLEAR = 1'b1;

  localparam logic [1:0] ST_REUSED  = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] block_size;
    logic [11:0] first_use;
    logic [11:0] last_use;
  } in_word_t;

  typedef struct packed {
    logic [39:0] placed_offset;
    logic [39:0] total_bytes;
    logic [1:0]  status;
  } out_word_t;

endpackage

FILE: rtl/core/greedy_by_size_offset_planner.sv
// ----------------------------------------------------------------------------
// greedy_by_size_offset_planner
// Assigns byte offsets to tensor lifetimes, reusing slots newest first.
// ----------------------------------------------------------------------------
//  channel | ports              | direction | word
//  input   | in_valid/in_ready  | in        | gbsop_pkg::in_word_t
//  result  | out_valid/out_ready| out       | gbsop_pkg::out_word_t
//
// Sequence: a clear or a word refused for a full record store shows its result
// in the cycle after acceptance. A place word walks slots newest to oldest:
// a slot too small is left after select, capacity read and size check; any
// other goes through select, capacity read, one step per stored record plus
// one for the record memory read latency, and decision; a commit step follows
// before the result is shown. Reset clears counts and total at once; the
// memories need no clearing. in_ready is low while an item is worked or its
// result waits in the output register.
module greedy_by_size_offset_planner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbsop_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gbsop_pkg::out_word_t out_data
);
  import gbsop_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_CAP, S_REC, S_CHK, S_COMMIT, S_OUT
  } state_t;

  state_t state_r;

  // memories
  logic [39:0] slot_base_mem [MAX_SLOTS];
  logic [31:0] slot_cap_mem  [MAX_SLOTS];
  logic [11:0] rec_first_mem [MAX_RECORDS];
  logic [11:0] rec_last_mem  [MAX_RECORDS];
  logic [SLOT_W-1:0] rec_slot_mem [MAX_RECORDS];

  logic [SCNT_W-1:0] slot_count_r;
  logic [RCNT_W-1:0] rec_count_r;
  logic [39:0]       total_r;
  in_word_t          item_r;
  logic [SCNT_W-1:0] j_r;       // slot under test
  logic [RCNT_W-1:0] r_r;       // record under test
  logic              hit_r;     // overlap seen in current slot
  logic              found_r;
  logic [31:0]       cap_q;
  logic [39:0]       base_q;
  logic [11:0]       rf_q, rl_q;
  logic [SLOT_W-1:0] rs_q;
  logic              rd_valid_r;
  out_word_t         out_r;

  logic [SLOT_W-1:0] jidx;
  logic [40:0]       new_total;
  assign jidx      = j_r[SLOT_W-1:0];
  assign new_total = {1'b0, total_r} + {9'd0, item_r.block_size};

  // registered memory reads
  always_ff @(posedge clk) begin
    cap_q  <= slot_cap_mem[jidx];
    base_q <= slot_base_mem[jidx];
    rf_q   <= rec_first_mem[r_r[REC_W-1:0]];
    rl_q   <= rec_last_mem[r_r[REC_W-1:0]];
    rs_q   <= rec_slot_mem[r_r[REC_W-1:0]];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= '0;
      rec_count_r  <= '0;
      total_r      <= '0;
      rd_valid_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          item_r  <= in_data;
          found_r <= 1'b0;
          j_r     <= slot_count_r;
          if (in_data.opcode == OP_CLEAR) begin
            slot_count_r <= '0;
            rec_count_r  <= '0;
            total_r      <= '0;
            out_r        <= '{40'd0, 40'd0, ST_CLEARED};
            state_r      <= S_OUT;
          end else if (rec_count_r == RCNT_W'(MAX_RECORDS)) begin
            out_r   <= '{40'd0, total_r, ST_FULL};
            state_r <= S_OUT;
          end else begin
            state_r <= S_SLOT;
          end
        end
        // pick next slot downward, or give up
        S_SLOT: begin
          if (j_r == '0) begin
            state_r <= S_COMMIT;
          end else begin
            j_r     <= j_r - 1'b1;
            state_r <= S_CAP;
          end
        end
        // capacity is read; start record walk
        S_CAP: begin
          r_r        <= '0;
          hit_r      <= 1'b0;
          rd_valid_r <= 1'b0;
          state_r    <= S_REC;
        end
        // one stored record per cycle; read data lags its address by one register
        S_REC: begin
          if (cap_q < item_r.block_size) begin
            state_r <= S_SLOT;
          end else begin
            if (rd_valid_r && rs_q == jidx && item_r.first_use <= rl_q
                && rf_q <= item_r.last_use) hit_r <= 1'b1;
            if (r_r == rec_count_r) begin
              state_r <= S_CHK;
            end else begin
              r_r        <= r_r + 1'b1;
              rd_valid_r <= 1'b1;
            end
          end
        end
        // every stored record checked; reuse when none overlapped
        S_CHK: begin
          if (hit_r) begin
            state_r <= S_SLOT;
          end else begin
            found_r <= 1'b1;
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_r <= S_OUT;
          if (found_r) begin
            rec_first_mem[rec_count_r[REC_W-1:0]] <= item_r.first_use;
            rec_last_mem[rec_count_r[REC_W-1:0]]  <= item_r.last_use;
            rec_slot_mem[rec_count_r[REC_W-1:0]]  <= jidx;
            rec_count_r <= rec_count_r + 1'b1;
            out_r <= '{base_q, total_r, ST_REUSED};
          end else if (slot_count_r == SCNT_W'(MAX_SLOTS) || new_total[40]) begin
            out_r <= '{40'd0, total_r, ST_FULL};
          end else begin
            slot_base_mem[slot_count_r[SLOT_W-1:0]] <= total_r;
            slot_cap_mem[slot_count_r[SLOT_W-1:0]]  <= item_r.block_size;
            rec_first_mem[rec_count_r[REC_W-1:0]] <= item_r.first_use;
            rec_last_mem[rec_count_r[REC_W-1:0]]  <= item_r.last_use;
            rec_slot_mem[rec_count_r[REC_W-1:0]]  <= slot_count_r[SLOT_W-1:0];
            rec_count_r  <= rec_count_r + 1'b1;
            slot_count_r <= slot_count_r + 1'b1;
            total_r      <= new_total[39:0];
            out_r <= '{total_r, new_total[39:0], ST_NEW};
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/gbsop_checker.sv
// ----------------------------------------------------------------------------
// gbsop_checker
// Port-level checks for the offset planner, bound to the top level.
// ----------------------------------------------------------------------------
module gbsop_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input gbsop_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input gbsop_pkg::out_word_t out_data
);
  import gbsop_pkg::*;

  // never accepts while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");

  // clear reports zeros
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_CLEARED |->
      out_data.total_bytes == 40'd0 && out_data.placed_offset == 40'd0)
    else $error("clear result not zero");

  // accepted clear answers on the next cycle
  a_clr_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_CLEAR |=>
      out_valid && out_data.status == ST_CLEARED)
    else $error("clear not answered next cycle");

  // new slot starts no higher than the total
  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NEW |->
      out_data.placed_offset <= out_data.total_bytes)
    else $error("new slot beyond total");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
endmodule

bind greedy_by_size_offset_planner gbsop_checker u_chk (.*);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Offset planner testbench
// Drives place and clear words into the planner, predicts every result with
// an in-bench slot/record model and checks each result word field by field.
// Both channels idle at random; a directed part covers the edge cases, then
// random size-sorted plans with noise follow.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gbsop_pkg::*;

  localparam longint TOTAL_MAX   = (64'd1 << 40) - 1;
  localparam int     CYCLE_LIMIT = 5000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  greedy_by_size_offset_planner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Plan mirror
  logic [39:0] plan_base [MAX_SLOTS];
  logic [31:0] plan_cap [MAX_SLOTS];
  logic [11:0] rec_first [MAX_RECORDS];
  logic [11:0] rec_last [MAX_RECORDS];
  int          rec_slot [MAX_RECORDS];
  int          plan_slots;
  int          plan_recs;
  logic [39:0] plan_total;

  out_word_t   pending_results [$];
  int          error_count;
  int          words_sent;
  int          results_seen;
  int          cycle_count;
  bit          steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit lifetimes_overlap(logic [11:0] f1, logic [11:0] l1,
                                           logic [11:0] f2, logic [11:0] l2);
    return (f1 <= l2) && (f2 <= l1);
  endfunction

  // Work out the result of one accepted word and update the mirror
  function automatic out_word_t plan_word(in_word_t w);
    out_word_t r;
    bit        hit;
    bit        busy;
    int        pick;
    r    = '0;
    hit  = 1'b0;
    pick = 0;
    if (w.opcode == OP_CLEAR) begin
      plan_slots = 0;
      plan_recs  = 0;
      plan_total = '0;
      r.status   = ST_CLEARED;
      return r;
    end
    if (plan_recs >= MAX_RECORDS) begin
      r.total_bytes = plan_total;
      r.status      = ST_FULL;
      return r;
    end
    for (int s = plan_slots - 1; s >= 0 && !hit; s--) begin
      if (plan_cap[s] >= w.block_size) begin
        busy = 1'b0;
        for (int k = 0; k < plan_recs; k++)
          if (rec_slot[k] == s &&
              lifetimes_overlap(w.first_use, w.last_use, rec_first[k], rec_last[k]))
            busy = 1'b1;
        if (!busy) begin
          hit  = 1'b1;
          pick = s;
        end
      end
    end
    if (!hit) begin
      if (plan_slots >= MAX_SLOTS ||
          64'(plan_total) + 64'(w.block_size) > TOTAL_MAX) begin
        r.total_bytes = plan_total;
        r.status      = ST_FULL;
        return r;
      end
      pick           = plan_slots;
      plan_base[pick] = plan_total;
      plan_cap[pick]  = w.block_size;
      plan_slots++;
      plan_total = plan_total + 40'(w.block_size);
    end
    rec_first[plan_recs] = w.first_use;
    rec_last[plan_recs]  = w.last_use;
    rec_slot[plan_recs]  = pick;
    plan_recs++;
    r.placed_offset = plan_base[pick];
    r.total_bytes   = plan_total;
    r.status        = hit ? ST_REUSED : ST_NEW;
    return r;
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < 16);
  endfunction

  // Send one word; the mirror is updated once in_ready is seen high again
  task automatic send_word(logic op, logic [31:0] sz, logic [11:0] f, logic [11:0] l);
    in_word_t w;
    w.opcode     = op;
    w.block_size = sz;
    w.first_use  = f;
    w.last_use   = l;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results = {pending_results, plan_word(w)};
    words_sent++;
  endtask

  task automatic place(logic [31:0] sz, logic [11:0] f, logic [11:0] l);
    send_word(OP_PLACE, sz, f, l);
  endtask

  task automatic clear_plan();
    send_word(OP_CLEAR, $urandom, 12'($urandom), 12'($urandom));
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        error_count++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data.placed_offset !== exp_w.placed_offset) begin
          $display("%0t: placed_offset expected %h actual %h",
                   $time, exp_w.placed_offset, out_data.placed_offset);
          error_count++;
        end
        if (out_data.total_bytes !== exp_w.total_bytes) begin
          $display("%0t: total_bytes expected %h actual %h",
                   $time, exp_w.total_bytes, out_data.total_bytes);
          error_count++;
        end
        if (out_data.status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_w.status, out_data.status);
          error_count++;
        end
      end
    end
    out_ready <= rst_n && !idle_now();
  end

  // Edge values, zero size, reversed lifetime, reuse and clear
  task automatic test_directed();
    place(32'hFFFF_FFFF, 12'd0, 12'hFFF);
    place(32'd0, 12'd10, 12'd20);
    place(32'd0, 12'd21, 12'd30);
    place(32'd0, 12'd20, 12'd25);
    place(32'h8000_0000, 12'd5, 12'd5);
    place(32'h7FFF_FFFF, 12'h800, 12'h7FF);
    place(32'd1, 12'hFFF, 12'h000);
    place(32'h5555_5555, 12'hAAA, 12'h555);
    place(32'hAAAA_AAAA, 12'h555, 12'hAAA);
    clear_plan();
    place(32'd1000, 12'd0, 12'd4);
    place(32'd800, 12'd5, 12'd9);
    place(32'd800, 12'd4, 12'd4);
    place(32'd1200, 12'd10, 12'd12);
    place(32'd500, 12'd13, 12'd20);
    clear_plan();
    clear_plan();
  endtask

  // Fill all slots with overlapping lifetimes, then two more
  task automatic test_slot_store_full();
    clear_plan();
    for (int i = 0; i <= MAX_SLOTS; i++)
      place(32'(i + 1), 12'd0, 12'hFFF);
    place(32'd1, 12'd0, 12'd0);
    clear_plan();
  endtask

  // Fill the record store through one reused slot, then one more
  task automatic test_record_store_full();
    clear_plan();
    for (int i = 0; i < MAX_RECORDS; i++)
      place(32'd100, 12'(i * 3), 12'(i * 3 + 1));
    place(32'd1, 12'hFFE, 12'hFFF);
    clear_plan();
    place(32'd7, 12'd1, 12'd2);
  endtask

  // Size-sorted plans with random lifetimes, plus noise words
  task automatic test_random_plans(int n_words);
    int          plan_len;
    logic [31:0] sz;
    logic [11:0] f;
    while (words_sent < n_words) begin
      steady   = ($urandom_range(0, 9) == 0);
      plan_len = $urandom_range(1, 25);
      sz       = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000);
      clear_plan();
      for (int k = 0; k < plan_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          place($urandom, 12'($urandom), 12'($urandom));
        end else begin
          f = 12'($urandom_range(0, 40));
          place(sz, f, f + 12'($urandom_range(0, 10)));
          sz = sz - (sz >> $urandom_range(1, 4));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int drain;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    error_count = 0;
    words_sent  = 0;
    results_seen = 0;
    steady      = 1'b0;
    plan_slots  = 0;
    plan_recs   = 0;
    plan_total  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_slot_store_full();
    test_record_store_full();
    test_random_plans(400);
    in_valid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 2000000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("Sent %0d words and checked %0d results: edge cases, full slot and",
             words_sent, results_seen);
    $display("record stores, clears and random size-sorted plans with noise.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gbsop_pkg.sv
rtl/core/greedy_by_size_offset_planner.sv
rtl/core/gbsop_checker.sv
bench/testbench.sv
